// ===== design/rti_pkg.sv =====
// Shared types and constants for the ray/triangle intersection block.
package rti_pkg;

    // Item opcodes: three vertex loads and one ray test.
    typedef enum logic [1:0] {
        OP_LOAD0 = 2'd0,
        OP_LOAD1 = 2'd1,
        OP_LOAD2 = 2'd2,
        OP_RAY   = 2'd3
    } opcode_t;

    // Outcome codes of a ray test.
    typedef enum logic [2:0] {
        OUT_HIT      = 3'd0,
        OUT_PARALLEL = 3'd1,
        OUT_U_BAD    = 3'd2,
        OUT_V_BAD    = 3'd3,
        OUT_T_SMALL  = 3'd4
    } outcome_t;

    // Configuration register indexes.
    localparam logic [3:0] CFG_DET_EPSILON = 4'd0;
    localparam logic [3:0] CFG_T_MIN       = 4'd1;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int FIELD_WIDTH     = 32;

    localparam logic [31:0] DET_EPSILON_RESET = 32'd43;
    localparam logic [30:0] T_MIN_RESET       = 31'd0;

    // Request transaction: a vertex load or a ray.
    typedef struct packed {
        logic [1:0]              opcode;
        logic [FIELD_WIDTH-1:0]  point_x;
        logic [FIELD_WIDTH-1:0]  point_y;
        logic [FIELD_WIDTH-1:0]  point_z;
        logic [FIELD_WIDTH-1:0]  dir_x;
        logic [FIELD_WIDTH-1:0]  dir_y;
        logic [FIELD_WIDTH-1:0]  dir_z;
    } req_t;

    // Response transaction: one per ray.
    typedef struct packed {
        logic       hit;
        logic [2:0] outcome;
    } rsp_t;

endpackage

// ===== design/ray_triangle_intersect.sv =====
// Top level of the ray/triangle intersection block.
//
// Exact Moller-Trumbore ray/triangle test in signed Q16.16. Opcodes 0 to 2 load
// one vertex of the stored triangle and give no response; opcode 3 tests a ray
// and gives one response transaction with a hit flag and an outcome code. One
// request is taken every clock cycle while the staging register is empty or the
// queue has room. A ray passes the front staging register, the queue, and the
// multiply and compare pipeline of the back end, which ends in the response
// register. A held response stalls the back end, while the front end keeps
// taking requests until its four-entry queue and its staging register fill.
// Configuration registers are written through the plain write port; the user
// must write them only while no ray is in flight; the block does not enforce it.
module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  req_t                       req_data,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output rsp_t                       rsp_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int JOB_W = 3*COORD_WIDTH + 9*(COORD_WIDTH + 1);

    logic [31:0]      det_epsilon_reg;
    logic [30:0]      t_min_reg;
    logic             job_push, job_full, job_valid, job_pop;
    logic [JOB_W-1:0] push_data, head_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_epsilon_reg <= DET_EPSILON_RESET;
            t_min_reg       <= T_MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DET_EPSILON: det_epsilon_reg <= cfg_data[31:0];
                CFG_T_MIN:       t_min_reg       <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    rti_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .job_push  (job_push),
        .job_full  (job_full),
        .job_data  (push_data)
    );

    rti_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (push_data),
        .full       (job_full),
        .head_valid (job_valid),
        .head_data  (head_data),
        .pop        (job_pop)
    );

    rti_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_data    (head_data),
        .job_pop     (job_pop),
        .det_epsilon (det_epsilon_reg),
        .t_min       (t_min_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data)
    );

endmodule

// ===== design/rti_front.sv =====
// Front end: accepts transactions, keeps the triangle and forms the ray job.
module rti_front
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  req_t                                   req_data,
    output logic                                   job_push,
    input  logic                                   job_full,
    output logic [3*COORD_WIDTH+9*(COORD_WIDTH+1)-1:0] job_data
);

    localparam int C     = COORD_WIDTH;
    localparam int E     = COORD_WIDTH + 1;
    localparam int JOB_W = 3*C + 9*E;

    logic signed [C-1:0]  tri_reg [9];
    logic signed [C-1:0]  tri_next [9];
    logic                 fe_valid_reg, fe_valid_next;
    logic [JOB_W-1:0]     fe_job_reg, fe_job_next;
    logic signed [C-1:0]  pt [3];
    logic signed [C-1:0]  dr [3];
    logic [JOB_W-1:0]     job_calc;
    logic                 accept;

    assign pt[0] = $signed(req_data.point_x[C-1:0]);
    assign pt[1] = $signed(req_data.point_y[C-1:0]);
    assign pt[2] = $signed(req_data.point_z[C-1:0]);
    assign dr[0] = $signed(req_data.dir_x[C-1:0]);
    assign dr[1] = $signed(req_data.dir_y[C-1:0]);
    assign dr[2] = $signed(req_data.dir_z[C-1:0]);

    // The staging register drains into the queue whenever the queue has room.
    assign job_push  = fe_valid_reg && !job_full;
    assign req_ready = !fe_valid_reg || !job_full;
    assign accept    = req_valid && req_ready;
    assign job_data  = fe_job_reg;

    // Edges and origin offset from the triangle as it stands at acceptance.
    always_comb
    begin
        job_calc = '0;
        for (int i = 0; i < 3; i++)
        begin
            job_calc[i*C +: C]           = dr[i];
            job_calc[3*C + i*E +: E]     = E'(tri_reg[3+i]) - E'(tri_reg[i]);
            job_calc[3*C + 3*E + i*E +: E] = E'(tri_reg[6+i]) - E'(tri_reg[i]);
            job_calc[3*C + 6*E + i*E +: E] = E'(pt[i]) - E'(tri_reg[i]);
        end
    end

    // Vertex loads write the store; rays go to the staging register.
    always_comb
    begin
        tri_next      = tri_reg;
        fe_valid_next = fe_valid_reg && !job_push;
        fe_job_next   = fe_job_reg;
        if (accept)
        begin
            if (req_data.opcode == OP_RAY)
            begin
                fe_valid_next = 1'b1;
                fe_job_next   = job_calc;
            end
            else
            begin
                for (int s = 0; s < 3; s++)
                begin
                    if (req_data.opcode == 2'(s))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            tri_next[s*3+i] = pt[i];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                tri_reg[k] <= '0;
            end
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
            tri_reg      <= tri_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fe_job_reg <= fe_job_next;
    end

endmodule

// ===== design/rti_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
module rti_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
)
;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/rti_back.sv =====
// Back end: pipelined exact Moller-Trumbore evaluation and the result register.
module rti_back
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   job_valid,
    input  logic [3*COORD_WIDTH+9*(COORD_WIDTH+1)-1:0] job_data,
    output logic                                   job_pop,
    input  logic [31:0]                            det_epsilon,
    input  logic [30:0]                            t_min,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output rsp_t                                   rsp_data
);

    localparam int C   = COORD_WIDTH;
    localparam int E   = C + 1;
    localparam int P   = 2*C + 2;
    localparam int Q   = 2*C + 3;
    localparam int W   = 3*C + 8;
    localparam int NCH = (W + 31) / 32;
    localparam int TW  = W + 31;

    logic       en;
    logic [8:1] v_reg;
    logic       out_valid_reg;
    rsp_t       out_reg, out_next;

    // Unpacked job fields.
    logic signed [C-1:0] j_dir [3];
    logic signed [E-1:0] j_e1 [3], j_e2 [3], j_tv [3];

    // Stage 1: cross product terms.
    logic signed [C-1:0]   s1_dir [3];
    logic signed [E-1:0]   s1_e1 [3], s1_e2 [3], s1_tv [3];
    logic signed [2*C:0]   pa_reg [3], pb_reg [3];
    logic signed [2*C+1:0] qa_reg [3], qb_reg [3];

    // Stage 2: cross products.
    logic signed [C-1:0]   s2_dir [3];
    logic signed [E-1:0]   s2_e1 [3], s2_e2 [3], s2_tv [3];
    logic signed [P-1:0]   pv_reg [3];
    logic signed [Q-1:0]   qv_reg [3];

    // Stage 3: split partial products of the dot products.
    logic signed [2*C+1:0] dl_reg [3], ul_reg [3], vl_reg [3], tl_reg [3];
    logic signed [2*C+3:0] dh_reg [3], uh_reg [3], vh_reg [3], th_reg [3];

    // Stage 4: whole terms; stage 5: dot products.
    logic signed [W-1:0] dt_reg [3], ut_reg [3], vt_reg [3], tt_reg [3];
    logic signed [W-1:0] det_reg, un_reg, vn_reg, tn_reg;

    // Stage 6: sign-corrected numerators.
    logic signed [W-1:0] ad6_reg, un6_reg, vn6_reg, tn6_reg;
    logic                par6_reg;

    // Stage 7: range flags and t_min partial products.
    logic signed [W-1:0] tn7_reg;
    logic                par7_reg, ub7_reg, vb7_reg;
    logic [62:0]         part_reg [NCH];
    logic [NCH*32-1:0]   ad_pad;

    // Stage 8: t_min times |det|.
    logic signed [W-1:0] tn8_reg;
    logic                par8_reg, ub8_reg, vb8_reg;
    logic [TW-1:0]       tmad_reg, tmad_sum;

    logic signed [W+15:0] tn_scaled;
    logic                 t_bad;

    // The whole pipeline advances together unless the result is held.
    assign en        = !out_valid_reg || rsp_ready;
    assign job_pop   = en && job_valid;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            j_dir[i] = $signed(job_data[i*C +: C]);
            j_e1[i]  = $signed(job_data[3*C + i*E +: E]);
            j_e2[i]  = $signed(job_data[3*C + 3*E + i*E +: E]);
            j_tv[i]  = $signed(job_data[3*C + 6*E + i*E +: E]);
        end
    end

    // Control: valid bits shift along the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[7:1], job_valid};
            out_valid_reg <= v_reg[8];
        end
    end

    // Stages 1 and 2: the two cross products, one component per lane.
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_dir[i] <= j_dir[i];
                s1_e1[i]  <= j_e1[i];
                s1_e2[i]  <= j_e2[i];
                s1_tv[i]  <= j_tv[i];
                pa_reg[i] <= j_dir[J] * j_e2[K];
                pb_reg[i] <= j_dir[K] * j_e2[J];
                qa_reg[i] <= j_tv[J] * j_e1[K];
                qb_reg[i] <= j_tv[K] * j_e1[J];

                s2_dir[i] <= s1_dir[i];
                s2_e1[i]  <= s1_e1[i];
                s2_e2[i]  <= s1_e2[i];
                s2_tv[i]  <= s1_tv[i];
                pv_reg[i] <= P'(pa_reg[i]) - P'(pb_reg[i]);
                qv_reg[i] <= Q'(qa_reg[i]) - Q'(qb_reg[i]);
            end
        end
    end

    // Stages 3 and 4: dot product terms, each split at bit C of the wide operand.
    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        logic signed [C:0]   pvl, qvl;
        logic signed [C+1:0] pvh;
        logic signed [C+2:0] qvh;

        assign pvl = $signed({1'b0, pv_reg[i][C-1:0]});
        assign qvl = $signed({1'b0, qv_reg[i][C-1:0]});
        assign pvh = $signed(pv_reg[i][P-1:C]);
        assign qvh = $signed(qv_reg[i][Q-1:C]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dl_reg[i] <= s2_e1[i] * pvl;
                dh_reg[i] <= s2_e1[i] * pvh;
                ul_reg[i] <= s2_tv[i] * pvl;
                uh_reg[i] <= s2_tv[i] * pvh;
                vl_reg[i] <= s2_dir[i] * qvl;
                vh_reg[i] <= s2_dir[i] * qvh;
                tl_reg[i] <= s2_e2[i] * qvl;
                th_reg[i] <= s2_e2[i] * qvh;

                dt_reg[i] <= (W'(dh_reg[i]) << C) + W'(dl_reg[i]);
                ut_reg[i] <= (W'(uh_reg[i]) << C) + W'(ul_reg[i]);
                vt_reg[i] <= (W'(vh_reg[i]) << C) + W'(vl_reg[i]);
                tt_reg[i] <= (W'(th_reg[i]) << C) + W'(tl_reg[i]);
            end
        end
    end

    // Stage 5 to stage 7: sums, sign correction and the range tests.
    always_comb
    begin
        ad_pad = (NCH*32)'($unsigned(ad6_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= dt_reg[0] + dt_reg[1] + dt_reg[2];
            un_reg  <= ut_reg[0] + ut_reg[1] + ut_reg[2];
            vn_reg  <= vt_reg[0] + vt_reg[1] + vt_reg[2];
            tn_reg  <= tt_reg[0] + tt_reg[1] + tt_reg[2];

            ad6_reg  <= det_reg[W-1] ? -det_reg : det_reg;
            un6_reg  <= det_reg[W-1] ? -un_reg : un_reg;
            vn6_reg  <= det_reg[W-1] ? -vn_reg : vn_reg;
            tn6_reg  <= det_reg[W-1] ? -tn_reg : tn_reg;
            par6_reg <= ((det_reg[W-1] ? -det_reg : det_reg)
                         <= $signed(W'({det_epsilon, 16'b0})));

            tn7_reg  <= tn6_reg;
            par7_reg <= par6_reg;
            ub7_reg  <= un6_reg[W-1] || (un6_reg > ad6_reg);
            vb7_reg  <= vn6_reg[W-1] || ((un6_reg + vn6_reg) > ad6_reg);
            for (int k = 0; k < NCH; k++)
            begin
                part_reg[k] <= t_min * ad_pad[k*32 +: 32];
            end

            tn8_reg  <= tn7_reg;
            par8_reg <= par7_reg;
            ub8_reg  <= ub7_reg;
            vb8_reg  <= vb7_reg;
            tmad_reg <= tmad_sum;

            out_reg  <= out_next;
        end
    end

    // Stage 8 adder: partial products weighted by their chunk position.
    always_comb
    begin
        tmad_sum = '0;
        for (int k = 0; k < NCH; k++)
        begin
            tmad_sum = tmad_sum + (TW'(part_reg[k]) << (32*k));
        end
    end

    // Final decision in the fixed priority of the test.
    always_comb
    begin
        tn_scaled = (W+16)'(tn8_reg) << 16;
        t_bad     = ((TW+1)'(tn_scaled) <= $signed({1'b0, tmad_reg}));
        out_next.hit = 1'b0;
        if (par8_reg)
        begin
            out_next.outcome = OUT_PARALLEL;
        end
        else if (ub8_reg)
        begin
            out_next.outcome = OUT_U_BAD;
        end
        else if (vb8_reg)
        begin
            out_next.outcome = OUT_V_BAD;
        end
        else if (t_bad)
        begin
            out_next.outcome = OUT_T_SMALL;
        end
        else
        begin
            out_next.outcome = OUT_HIT;
            out_next.hit     = 1'b1;
        end
    end

endmodule
